### rtl/sdfpf_pkg.sv
// shared types and constants for the plane flatten blend block
package sdfpf_pkg;

    localparam int POS_W      = 21;
    localparam int DIFF_W     = 22;
    localparam int NRM_W      = 16;
    localparam int WGT_W      = 17;
    localparam int CFG_W      = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 26;
    localparam int SQRT_STEPS = 22;
    localparam int TDIV_STEPS = 16;
    localparam int PDIV_STEPS = 40;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

    // clamp mode codes
    localparam logic [1:0] MODE_BOTH = 2'd0;
    localparam logic [1:0] MODE_CUT  = 2'd1;
    localparam logic [1:0] MODE_FILL = 2'd2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_DIR      = 3'd0,
        CFG_PLANE_ORIGIN   = 3'd1,
        CFG_REGION_CENTER  = 3'd2,
        CFG_FULL_RADIUS    = 3'd3,
        CFG_TAPER_WIDTH    = 3'd4,
        CFG_BLEND_STRENGTH = 3'd5,
        CFG_CLAMP_MODE     = 3'd6
    } cfg_idx_t;

    // settings seen by the datapath
    typedef struct packed {
        logic [47:0]      plane_dir;
        logic [19:0]      radius;
        logic [19:0]      taper;
        logic [16:0]      strength;
        logic [1:0]       mode;
        logic [LEN_W-1:0] plane_len;
    } cfg_t;

    // classified item held in the queue
    typedef struct packed {
        logic signed [DIFF_W-1:0] dc_x;
        logic signed [DIFF_W-1:0] dc_y;
        logic signed [DIFF_W-1:0] dc_z;
        logic signed [DIFF_W-1:0] do_x;
        logic signed [DIFF_W-1:0] do_y;
        logic signed [DIFF_W-1:0] do_z;
        logic signed [POS_W-1:0]  src;
        logic [WGT_W-1:0]         freeze;
        logic                     pass;
    } item_t;

endpackage

### rtl/sdfpf_if.sv
// sample and result channel interfaces
interface sdfpf_in_if import sdfpf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] source_dist;
    logic [WGT_W-1:0]        freeze_amount;

    modport source (output valid, pos_x, pos_y, pos_z, source_dist, freeze_amount,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, source_dist, freeze_amount,
                  output ready);
endinterface

interface sdfpf_out_if import sdfpf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] flattened_dist;
    logic [WGT_W-1:0]        applied_weight;

    modport source (output valid, flattened_dist, applied_weight, input ready);
    modport sink (input valid, flattened_dist, applied_weight, output ready);
endinterface

### rtl/sdfpf_front.sv
// register file, plane length sequencer and item classification
module sdfpf_front import sdfpf_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    sdfpf_in_if.sink             sample_in,
    input  logic                 q_ready,
    output logic                 q_push,
    output item_t                q_item,
    output cfg_t                 cfg
);

    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_SQR  = 4'b0010,
        SEQ_SUM  = 4'b0100,
        SEQ_ROOT = 4'b1000
    } seq_state_t;

    logic [47:0] dir_reg;
    logic [62:0] origin_reg;
    logic [62:0] center_reg;
    logic [19:0] radius_reg;
    logic [19:0] taper_reg;
    logic [16:0] strength_reg;
    logic [1:0]  mode_reg;

    seq_state_t  state_reg, state_next;
    logic [30:0] sqx_reg, sqy_reg, sqz_reg;
    logic [31:0] n2_reg;
    logic [51:0] rad_reg;
    logic [27:0] rt_rem_reg;
    logic [LEN_W-1:0] rt_root_reg, len_reg;
    logic [4:0]  cnt_reg;

    logic signed [NRM_W-1:0] nx, ny, nz;
    logic signed [31:0] nx2, ny2, nz2;
    logic [29:0] rt_tmp, rt_trial;
    logic        rt_ge;
    logic [27:0] rt_rem_next;
    logic [LEN_W-1:0] rt_root_next;
    logic        busy;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= '0;
            origin_reg   <= '0;
            center_reg   <= '0;
            radius_reg   <= '0;
            taper_reg    <= 20'd1;
            strength_reg <= '0;
            mode_reg     <= MODE_BOTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_PLANE_DIR:      dir_reg      <= cfg_data[47:0];
                CFG_PLANE_ORIGIN:   origin_reg   <= cfg_data;
                CFG_REGION_CENTER:  center_reg   <= cfg_data;
                CFG_FULL_RADIUS:    radius_reg   <= cfg_data[19:0];
                CFG_TAPER_WIDTH:    taper_reg    <= cfg_data[19:0];
                CFG_BLEND_STRENGTH: strength_reg <= cfg_data[16:0];
                CFG_CLAMP_MODE:     mode_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // normal squares
    assign nx  = dir_reg[15:0];
    assign ny  = dir_reg[31:16];
    assign nz  = dir_reg[47:32];
    assign nx2 = nx * nx;
    assign ny2 = ny * ny;
    assign nz2 = nz * nz;

    // one root bit per cycle of |n|^2 << 20
    assign rt_tmp       = {rt_rem_reg, rad_reg[51:50]};
    assign rt_trial     = {2'b00, rt_root_reg, 2'b01};
    assign rt_ge        = rt_tmp >= rt_trial;
    assign rt_rem_next  = rt_ge ? 28'(rt_tmp - rt_trial) : rt_tmp[27:0];
    assign rt_root_next = {rt_root_reg[LEN_W-2:0], rt_ge};

    // sequencer next state, a direction write restarts it
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: state_next = SEQ_IDLE;
            SEQ_SQR:  state_next = SEQ_SUM;
            SEQ_SUM:  state_next = SEQ_ROOT;
            SEQ_ROOT: state_next = (cnt_reg == 5'd25) ? SEQ_IDLE : SEQ_ROOT;
            default:  state_next = SEQ_IDLE;
        endcase
        if (cfg_we && cfg_idx_t'(cfg_idx) == CFG_PLANE_DIR)
            state_next = SEQ_SQR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            n2_reg    <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SEQ_SUM)
            begin
                n2_reg  <= 32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg);
                cnt_reg <= '0;
            end
            else if (state_reg == SEQ_ROOT)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd25)
                    len_reg <= rt_root_next;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == SEQ_SQR)
        begin
            sqx_reg <= nx2[30:0];
            sqy_reg <= ny2[30:0];
            sqz_reg <= nz2[30:0];
        end
        if (state_reg == SEQ_SUM)
        begin
            rad_reg     <= {32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg), 20'd0};
            rt_rem_reg  <= '0;
            rt_root_reg <= '0;
        end
        else if (state_reg == SEQ_ROOT)
        begin
            rad_reg     <= {rad_reg[49:0], 2'b00};
            rt_rem_reg  <= rt_rem_next;
            rt_root_reg <= rt_root_next;
        end
    end

    assign busy = state_reg != SEQ_IDLE;

    // accept and classify
    assign sample_in.ready = q_ready && !busy;
    assign q_push          = sample_in.valid && sample_in.ready;

    always_comb
    begin
        q_item.dc_x   = DIFF_W'(sample_in.pos_x) - DIFF_W'($signed(center_reg[20:0]));
        q_item.dc_y   = DIFF_W'(sample_in.pos_y) - DIFF_W'($signed(center_reg[41:21]));
        q_item.dc_z   = DIFF_W'(sample_in.pos_z) - DIFF_W'($signed(center_reg[62:42]));
        q_item.do_x   = DIFF_W'(sample_in.pos_x) - DIFF_W'($signed(origin_reg[20:0]));
        q_item.do_y   = DIFF_W'(sample_in.pos_y) - DIFF_W'($signed(origin_reg[41:21]));
        q_item.do_z   = DIFF_W'(sample_in.pos_z) - DIFF_W'($signed(origin_reg[62:42]));
        q_item.src    = sample_in.source_dist;
        q_item.freeze = sample_in.freeze_amount;
        q_item.pass   = (n2_reg == '0) || (strength_reg == '0) || (radius_reg == '0);
    end

    // settings for the back end, with floors and saturation applied
    always_comb
    begin
        cfg.plane_dir = dir_reg;
        cfg.radius    = radius_reg;
        cfg.taper     = (taper_reg == '0) ? 20'd1 : taper_reg;
        cfg.strength  = (strength_reg > ONE_Q16) ? ONE_Q16 : strength_reg;
        cfg.mode      = mode_reg;
        cfg.plane_len = len_reg;
    end

endmodule

### rtl/sdfpf_queue.sv
// short item queue between front and back
module sdfpf_queue import sdfpf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/sdfpf_back.sv
// weight and plane pipeline, one item per stage
module sdfpf_back import sdfpf_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    sdfpf_out_if.source result_out
);

    localparam int ST_SUM   = 2;
    localparam int ST_CLS   = ST_SUM + SQRT_STEPS + 1;
    localparam int ST_T2    = ST_CLS + TDIV_STEPS + 1;
    localparam int ST_WREG  = ST_T2 + 1;
    localparam int ST_W1    = ST_WREG + 1;
    localparam int ST_W     = ST_W1 + 1;
    localparam int ST_MUL   = ST_W + 1;
    localparam int ST_OUT   = ST_MUL + 1;
    localparam int ST_PLANE = ST_SUM + PDIV_STEPS + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] src;
        logic [WGT_W-1:0]        gate;
        logic                    pass;
    } side_t;

    logic [ST_OUT:1] v_reg;
    side_t           side_reg [1:ST_OUT];
    side_t           side_in;
    logic            en;

    assign en    = !v_reg[ST_OUT] || result_out.ready;
    assign q_pop = en && q_valid;

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ST_OUT-1:1], q_valid};
    end

    // item side fields follow the item down
    always_comb
    begin
        side_in.src  = q_item.src;
        side_in.gate = ONE_Q16 - ((q_item.freeze > ONE_Q16) ? ONE_Q16 : q_item.freeze);
        side_in.pass = q_item.pass;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= side_in;
            for (int i = 2; i <= ST_OUT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // squares and normal products
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic signed [43:0] sqx_c, sqy_c, sqz_c;
    logic signed [37:0] npx_c, npy_c, npz_c;
    logic signed [43:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [37:0] npx_reg, npy_reg, npz_reg;
    logic [43:0]        d2_reg;
    logic signed [39:0] dot_reg;

    assign nx    = cfg.plane_dir[15:0];
    assign ny    = cfg.plane_dir[31:16];
    assign nz    = cfg.plane_dir[47:32];
    assign sqx_c = q_item.dc_x * q_item.dc_x;
    assign sqy_c = q_item.dc_y * q_item.dc_y;
    assign sqz_c = q_item.dc_z * q_item.dc_z;
    assign npx_c = nx * q_item.do_x;
    assign npy_c = ny * q_item.do_y;
    assign npz_c = nz * q_item.do_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= sqx_c;
            sqy_reg <= sqy_c;
            sqz_reg <= sqz_c;
            npx_reg <= npx_c;
            npy_reg <= npy_c;
            npz_reg <= npz_c;
            d2_reg  <= sqx_reg + sqy_reg + sqz_reg;
            dot_reg <= 40'(npx_reg) + 40'(npy_reg) + 40'(npz_reg);
        end
    end

    // distance to center, one root bit per stage
    logic [25:0] sq_rem_reg  [1:SQRT_STEPS];
    logic [21:0] sq_root_reg [1:SQRT_STEPS];
    logic [43:0] sq_val_reg  [1:SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [25:0] prev_rem, tmp, trial;
        logic [21:0] prev_root;
        logic [43:0] prev_val;
        logic        ge;
        if (k == 0)
        begin : g_first
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_val  = d2_reg;
        end
        else
        begin : g_next
            assign prev_rem  = sq_rem_reg[k];
            assign prev_root = sq_root_reg[k];
            assign prev_val  = sq_val_reg[k];
        end
        assign tmp   = {prev_rem[23:0], prev_val[43-2*k -: 2]};
        assign trial = {2'b00, prev_root, 2'b01};
        assign ge    = tmp >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k+1]  <= ge ? tmp - trial : tmp;
                sq_root_reg[k+1] <= {prev_root[20:0], ge};
                sq_val_reg[k+1]  <= prev_val;
            end
        end
    end

    // inside, band or outside
    logic [21:0] ctr_dist, over;
    logic        full_c, zero_c;
    logic        cls_full_reg, cls_zero_reg;
    logic [19:0] cls_rem_reg;

    assign ctr_dist = sq_root_reg[SQRT_STEPS];
    assign over     = ctr_dist - 22'(cfg.radius);
    assign full_c   = ctr_dist <= 22'(cfg.radius);
    assign zero_c   = !full_c && (over >= 22'(cfg.taper));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_full_reg <= full_c;
            cls_zero_reg <= zero_c;
            cls_rem_reg  <= over[19:0];
        end
    end

    // taper parameter, one quotient bit per stage
    logic [19:0] td_rem_reg  [1:TDIV_STEPS];
    logic [15:0] td_q_reg    [1:TDIV_STEPS];
    logic        td_full_reg [1:TDIV_STEPS];
    logic        td_zero_reg [1:TDIV_STEPS];

    for (genvar k = 0; k < TDIV_STEPS; k++)
    begin : g_tdiv
        logic [19:0] prev_rem;
        logic [15:0] prev_q;
        logic        prev_full, prev_zero, ge;
        logic [20:0] tmp;
        if (k == 0)
        begin : g_first
            assign prev_rem  = cls_rem_reg;
            assign prev_q    = '0;
            assign prev_full = cls_full_reg;
            assign prev_zero = cls_zero_reg;
        end
        else
        begin : g_next
            assign prev_rem  = td_rem_reg[k];
            assign prev_q    = td_q_reg[k];
            assign prev_full = td_full_reg[k];
            assign prev_zero = td_zero_reg[k];
        end
        assign tmp = {prev_rem, 1'b0};
        assign ge  = tmp >= 21'(cfg.taper);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                td_rem_reg[k+1]  <= ge ? 20'(tmp - 21'(cfg.taper)) : tmp[19:0];
                td_q_reg[k+1]    <= {prev_q[14:0], ge};
                td_full_reg[k+1] <= prev_full;
                td_zero_reg[k+1] <= prev_zero;
            end
        end
    end

    // smoothstep and weight products
    logic [15:0] t_reg, t2_reg;
    logic        full_reg, zero_reg;
    logic [31:0] tt_c;
    logic [17:0] m_c, s_c;
    logic [33:0] s_prod;
    logic [16:0] wreg_reg, w1_reg, w_reg;
    logic [33:0] w1_prod, w_prod;

    assign tt_c    = 32'(td_q_reg[TDIV_STEPS]) * 32'(td_q_reg[TDIV_STEPS]);
    assign m_c     = 18'd196608 - {1'b0, t_reg, 1'b0};
    assign s_prod  = 34'(t2_reg) * 34'(m_c);
    assign s_c     = s_prod[33:16];
    assign w1_prod = 34'(wreg_reg) * 34'(cfg.strength);
    assign w_prod  = 34'(w1_reg) * 34'(side_reg[ST_W1].gate);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= td_q_reg[TDIV_STEPS];
            t2_reg   <= tt_c[31:16];
            full_reg <= td_full_reg[TDIV_STEPS];
            zero_reg <= td_zero_reg[TDIV_STEPS];
            if (full_reg)
                wreg_reg <= ONE_Q16;
            else if (zero_reg)
                wreg_reg <= '0;
            else
                wreg_reg <= ONE_Q16 - ((s_c > 18'(ONE_Q16)) ? ONE_Q16 : s_c[16:0]);
            w1_reg <= w1_prod[32:16];
            w_reg  <= w_prod[32:16];
        end
    end

    // plane distance, rounded quotient one bit per stage
    logic [39:0] dot_mag;
    logic [49:0] num0;
    logic [25:0] pd_rem_reg [1:PDIV_STEPS];
    logic [39:0] pd_q_reg   [1:PDIV_STEPS];
    logic [39:0] pd_num_reg [1:PDIV_STEPS];
    logic        pd_neg_reg [1:PDIV_STEPS];

    assign dot_mag = dot_reg[39] ? 40'(-dot_reg) : 40'(dot_reg);
    assign num0    = {dot_mag, 10'd0} + 50'(cfg.plane_len >> 1);

    for (genvar k = 0; k < PDIV_STEPS; k++)
    begin : g_pdiv
        logic [25:0] prev_rem;
        logic [39:0] prev_q, prev_num;
        logic        prev_neg, ge;
        logic [26:0] tmp;
        if (k == 0)
        begin : g_first
            assign prev_rem = 26'(num0[49:40]);
            assign prev_q   = '0;
            assign prev_num = num0[39:0];
            assign prev_neg = dot_reg[39];
        end
        else
        begin : g_next
            assign prev_rem = pd_rem_reg[k];
            assign prev_q   = pd_q_reg[k];
            assign prev_num = pd_num_reg[k];
            assign prev_neg = pd_neg_reg[k];
        end
        assign tmp = {prev_rem, prev_num[39-k]};
        assign ge  = tmp >= 27'(cfg.plane_len);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pd_rem_reg[k+1] <= ge ? 26'(tmp - 27'(cfg.plane_len)) : tmp[25:0];
                pd_q_reg[k+1]   <= {prev_q[38:0], ge};
                pd_num_reg[k+1] <= prev_num;
                pd_neg_reg[k+1] <= prev_neg;
            end
        end
    end

    // pull toward the plane with clamp mode
    logic signed [40:0] plane_reg;
    logic signed [41:0] tow_c, tow_reg, tow_d_reg;
    logic [40:0]        q_ext;

    assign q_ext = {1'b0, pd_q_reg[PDIV_STEPS]};
    assign tow_c = 42'(plane_reg) - 42'(side_reg[ST_PLANE].src);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plane_reg <= pd_neg_reg[PDIV_STEPS] ? -$signed(q_ext) : $signed(q_ext);
            if (cfg.mode == MODE_CUT && tow_c < 0)
                tow_reg <= '0;
            else if (cfg.mode == MODE_FILL && tow_c > 0)
                tow_reg <= '0;
            else
                tow_reg <= tow_c;
            tow_d_reg <= tow_reg;
        end
    end

    // scaled offset, rounding and saturation
    logic signed [59:0] prod_c, prod_reg;
    logic               pass_reg;
    logic [16:0]        wout_mul_reg;
    logic [59:0]        pmag;
    logic [43:0]        qm;
    logic signed [44:0] off, sum;
    logic signed [POS_W-1:0] res_reg, src_out;
    logic [WGT_W-1:0]   wout_reg;
    logic               pass_c;

    assign pass_c = side_reg[ST_W].pass || (w_reg == '0);
    assign prod_c = tow_d_reg * $signed({1'b0, w_reg});
    assign pmag   = prod_reg[59] ? 60'(-prod_reg) : 60'(prod_reg);
    assign qm     = 44'((pmag + 60'd32768) >> 16);
    assign off    = prod_reg[59] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    assign src_out = side_reg[ST_MUL].src;
    assign sum    = 45'(src_out) + off;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= prod_c;
            pass_reg     <= pass_c;
            wout_mul_reg <= pass_c ? '0 : w_reg;
            wout_reg     <= wout_mul_reg;
            if (pass_reg)
                res_reg <= src_out;
            else if (sum < -45'sd1048576)
                res_reg <= -21'sd1048576;
            else if (sum > 45'sd1048575)
                res_reg <= 21'sd1048575;
            else
                res_reg <= sum[POS_W-1:0];
        end
    end

    assign result_out.valid          = v_reg[ST_OUT];
    assign result_out.flattened_dist = res_reg;
    assign result_out.applied_weight = wout_reg;

endmodule

### rtl/sdf_plane_flatten_blend.sv
// top level of the plane flatten blend block
//
//  channel     dir  handshake      payload
//  sample_in   in   valid/ready    pos_x, pos_y, pos_z, source_dist, freeze_amount
//  result_out  out  valid/ready    flattened_dist, applied_weight
//  cfg         in   cfg_we         cfg_idx, cfg_data
//
// one item per cycle while result_out is taken and the length sequencer is idle; the back
// pipeline holds the 40 stage plane divider and the 22 stage root plus 16 stage taper divider
// a plane direction write starts the square, sum and root length sequencer, sample_in.ready is low
// meanwhile; reset clears control state only
// a stalled result freezes the back pipeline while the queue keeps taking items until it is full
module sdf_plane_flatten_blend import sdfpf_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    sdfpf_in_if.sink             sample_in,
    sdfpf_out_if.source          result_out
);

    cfg_t  cfg;
    item_t push_item, pop_item;
    logic  push, push_ready, pop, pop_valid;

    sdfpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .sample_in (sample_in),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_item    (push_item),
        .cfg       (cfg)
    );

    sdfpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    sdfpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (pop_valid),
        .q_item     (pop_item),
        .q_pop      (pop),
        .result_out (result_out)
    );

endmodule

### rtl/sdfpf_checker.sv
// port level checks for the plane flatten blend block
module sdfpf_checker import sdfpf_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [POS_W-1:0] out_dist,
    input logic [WGT_W-1:0]        out_weight
);

    logic [7:0] pending_reg;
    logic       in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // items accepted and not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_fire && !out_fire)
            pending_reg <= pending_reg + 8'd1;
        else if (!in_fire && out_fire)
            pending_reg <= pending_reg - 8'd1;
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_dist) && $stable(out_weight))
        else $error("result changed while stalled");

    // weight never above one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_weight <= ONE_Q16)
        else $error("weight above one");

    // no result without an item behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without an accepted item");

    // nothing shown during reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind sdf_plane_flatten_blend sdfpf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_in.valid),
    .in_ready   (sample_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_dist   (result_out.flattened_dist),
    .out_weight (result_out.applied_weight)
);
